>>> rtl/fbpa_pkg.sv
// Package: shared constants, codes and helpers of the block pool allocator.
package fbpa_pkg;

  localparam int ADDR_W    = 21;
  localparam int CNT_W     = 17;
  localparam int REQ_W     = 12;
  localparam int MODE_W    = 2;
  localparam int OP_W      = 2;
  localparam int ST_W      = 3;
  localparam int CFG_IDX_W = 2;
  localparam int KW        = 9;   // block size in 16-byte units, 1..256

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_PURGE = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK            = 3'd0,
    ST_NO_PAGES      = 3'd1,
    ST_MISALIGNED    = 3'd2,
    ST_OUTSIDE       = 3'd3,
    ST_PURGE_REFUSED = 3'd4
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BLOCK_REQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_API_MODE  = 2'd1;

  localparam logic [MODE_W-1:0] MODE_SMALL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LARGE = 2'd1;

  localparam logic [ADDR_W-1:0] PAGE_BYTES_SMALL = 21'd4096;
  localparam logic [ADDR_W-1:0] PAGE_BYTES_LARGE = 21'd409600;
  localparam logic [ADDR_W-1:0] PAGE_BYTES_ALT   = 21'd393216;

  localparam logic [REQ_W-1:0] REQ_RESET  = 12'd16;
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_LARGE;

  // block size in 16-byte units: request rounded up, at least one unit
  function automatic logic [KW-1:0] block_units(input logic [REQ_W-1:0] req);
    logic [REQ_W:0] r;
    r = {1'b0, req};
    if (req < 12'd16) begin
      r = 13'd16;
    end
    r = r + 13'd15;
    return r[REQ_W:4];
  endfunction

endpackage

>>> rtl/fbpa_if.sv
// Interfaces: request, response and configuration channels.
interface fbpa_req_if import fbpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ADDR_W-1:0] address;
  modport source(output valid, operation, address, input ready);
  modport sink(input valid, operation, address, output ready);
endinterface

interface fbpa_rsp_if import fbpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [ADDR_W-1:0] block_address;
  logic [CNT_W-1:0]  blocks_in_use;
  modport source(output valid, status, block_address, blocks_in_use, input ready);
  modport sink(input valid, status, block_address, blocks_in_use, output ready);
endinterface

interface fbpa_cfg_if import fbpa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REQ_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/fbpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/fixed_block_pool_allocator.sv
// Top level: fixed-size block pool allocator with a LIFO free list of runs.
//
// One request word at a time: allocate, free, purge or no-op. The block hands out
// fixed-size blocks from up to MAX_PAGES page slots, each 2^PAGE_STRIDE_BITS
// bytes apart, first block at byte 16. Free runs live in one RAM of
// MAX_PAGES*BLOCKS_PER_PAGE entries (link + run length), one entry per
// 16-byte unit; entries are never cleared, so there is no clearing pass
// after reset. Work per word: allocate from a non-empty list reads the head
// entry, splits or pops its run, then finds the slot s (0..MAX_PAGES-1) of
// the block by a subtract loop; allocate that opens a page first sizes the
// run with the shared 1-bit-per-cycle divider; free uses the same divider to
// check alignment; purge, no-ops, null frees and rejected words go straight
// to the response. req.ready is high only while idle. A finished response
// sits in an output register, so the next word is taken while it waits.
// Configuration writes are taken at any time but must come only while idle.
module fixed_block_pool_allocator import fbpa_pkg::*; #(
  parameter int MAX_PAGES        = 4,
  parameter int BLOCKS_PER_PAGE  = 32768,
  parameter int PAGE_STRIDE_BITS = 19
) (
  input logic         clk_i,
  input logic         rst_ni,
  fbpa_cfg_if.sink    cfg,
  fbpa_req_if.sink    req,
  fbpa_rsp_if.source  rsp
);

  localparam int DEPTH = MAX_PAGES * BLOCKS_PER_PAGE;
  localparam int IW    = $clog2(DEPTH);            // unit index
  localparam int RW    = $clog2(BLOCKS_PER_PAGE);  // run length
  localparam int PW    = $clog2(MAX_PAGES + 1);    // open page count
  localparam int SW    = ADDR_W - PAGE_STRIDE_BITS;
  localparam int DW    = PAGE_STRIDE_BITS - 4;     // dividend, in 16-byte units
  localparam int DCW   = $clog2(DW + 1);
  localparam int CAP_STRIDE = 1 << PAGE_STRIDE_BITS;
  localparam int CAP_BLK    = BLOCKS_PER_PAGE * 16;
  localparam int CAP        = (CAP_STRIDE < CAP_BLK) ? CAP_STRIDE : CAP_BLK;
  localparam logic [ADDR_W-1:0] PAGE_CAP = ADDR_W'(CAP);
  localparam logic [IW-1:0] BPP_U = IW'(BLOCKS_PER_PAGE);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIV   = 8'b0000_0010,
    S_POST  = 8'b0000_0100,
    S_RD    = 8'b0000_1000,
    S_WAIT  = 8'b0001_0000,
    S_ALLOC = 8'b0010_0000,
    S_ADDR  = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_e;

  // configuration
  logic [REQ_W-1:0]  blk_req_q;
  logic [MODE_W-1:0] mode_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_req_q <= REQ_RESET;
      mode_q    <= MODE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_IDX_BLOCK_REQ: blk_req_q <= cfg.data;
        CFG_IDX_API_MODE:  mode_q    <= cfg.data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [KW-1:0]     k_units;
  logic [ADDR_W-1:0] page_raw;
  logic [ADDR_W-1:0] page_bytes;
  logic              counted;

  assign k_units = block_units(blk_req_q);
  assign counted = (mode_q != MODE_SMALL);

  always_comb begin
    case (mode_q)
      MODE_SMALL: page_raw = PAGE_BYTES_SMALL;
      MODE_LARGE: page_raw = PAGE_BYTES_LARGE;
      default:    page_raw = PAGE_BYTES_ALT;
    endcase
    page_bytes = (page_raw > PAGE_CAP) ? PAGE_CAP : page_raw;
  end

  // state
  state_e              state_q, state_d;
  op_e                 op_q, op_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [IW-1:0]       head_q, head_d;
  logic [PW-1:0]       pages_q, pages_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [DW-1:0]       dvd_q, dvd_d;
  logic [DW-1:0]       quo_q, quo_d;
  logic [KW-1:0]       rem_q, rem_d;
  logic [DCW-1:0]      dcnt_q, dcnt_d;
  logic [IW-1:0]       h_q, h_d;
  logic [IW-1:0]       link_q, link_d;
  logic [RW-1:0]       run_q, run_d;
  logic [IW-1:0]       urem_q, urem_d;
  logic [PW-1:0]       slot_q, slot_d;
  status_e             st_q, st_d;
  logic [ADDR_W-1:0]   baddr_q, baddr_d;

  // response register
  logic                rsp_valid_q, rsp_valid_d;
  logic [ST_W-1:0]     rsp_st_q, rsp_st_d;
  logic [ADDR_W-1:0]   rsp_addr_q, rsp_addr_d;
  logic [CNT_W-1:0]    rsp_cnt_q, rsp_cnt_d;

  // free list RAM
  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [IW+RW-1:0]    ram_wdata;
  logic                ram_re;
  logic [IW+RW-1:0]    ram_rdata;

  fbpa_ram #(
    .WIDTH(IW + RW),
    .DEPTH(DEPTH)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // request address split
  logic [SW-1:0]               f_slot, q_slot;
  logic [PAGE_STRIDE_BITS-1:0] f_off, q_off;
  logic                        f_outside, f_misal;

  assign f_slot = req.address[ADDR_W-1:PAGE_STRIDE_BITS];
  assign f_off  = req.address[PAGE_STRIDE_BITS-1:0];
  assign q_slot = addr_q[ADDR_W-1:PAGE_STRIDE_BITS];
  assign q_off  = addr_q[PAGE_STRIDE_BITS-1:0];

  assign f_outside = (ADDR_W'(f_slot) >= ADDR_W'(pages_q)) ||
                     (f_off < PAGE_STRIDE_BITS'(8)) ||
                     (ADDR_W'(f_off) >= page_bytes);
  assign f_misal   = (f_off < PAGE_STRIDE_BITS'(16)) || (f_off[3:0] != 4'd0);

  // shared divider step: restoring, one quotient bit per cycle
  logic [KW:0] div_sh;
  logic        div_ge;

  assign div_sh = {rem_q, dvd_q[DW-1]};
  assign div_ge = (div_sh >= {1'b0, k_units});

  // split successor of the head run, wrapped into the store
  logic [IW:0] nxt_sum;
  logic [IW-1:0] nxt_unit;

  assign nxt_sum  = (IW+1)'(h_q) + (IW+1)'(k_units);
  assign nxt_unit = (nxt_sum >= (IW+1)'(DEPTH)) ? IW'(nxt_sum - (IW+1)'(DEPTH))
                                                 : nxt_sum[IW-1:0];

  logic rsp_free;
  assign rsp_free = !rsp_valid_q || rsp.ready;

  assign req.ready     = (state_q == S_IDLE);
  assign rsp.valid     = rsp_valid_q;
  assign rsp.status    = rsp_st_q;
  assign rsp.block_address = rsp_addr_q;
  assign rsp.blocks_in_use = rsp_cnt_q;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    addr_d  = addr_q;
    head_d  = head_q;
    pages_d = pages_q;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dcnt_d  = dcnt_q;
    h_d     = h_q;
    link_d  = link_q;
    run_d   = run_q;
    urem_d  = urem_q;
    slot_d  = slot_q;
    st_d    = st_q;
    baddr_d = baddr_q;
    ram_we    = 1'b0;
    ram_waddr = h_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    rsp_valid_d = rsp_valid_q && !rsp.ready;
    rsp_st_d    = rsp_st_q;
    rsp_addr_d  = rsp_addr_q;
    rsp_cnt_d   = rsp_cnt_q;

    case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          op_d    = op_e'(req.operation);
          addr_d  = req.address;
          st_d    = ST_OK;
          baddr_d = '0;
          rem_d   = '0;
          quo_d   = '0;
          dcnt_d  = DCW'(DW);
          state_d = S_FIN;
          case (op_e'(req.operation))
            OP_ALLOC: begin
              if (head_q != '0) begin
                state_d = S_RD;
              end else if (pages_q >= PW'(MAX_PAGES)) begin
                st_d = ST_NO_PAGES;
              end else begin
                // size the new page's run
                dvd_d   = DW'((page_bytes - ADDR_W'(16)) >> 4);
                state_d = S_DIV;
              end
            end
            OP_FREE: begin
              if (req.address == '0) begin
                st_d = ST_OK;
              end else if (f_outside) begin
                st_d = ST_OUTSIDE;
              end else if (f_misal) begin
                st_d = ST_MISALIGNED;
              end else begin
                dvd_d   = DW'((f_off - PAGE_STRIDE_BITS'(16)) >> 4);
                state_d = S_DIV;
              end
            end
            OP_PURGE: begin
              if (counted && cnt_q != '0) begin
                st_d = ST_PURGE_REFUSED;
              end else begin
                pages_d = '0;
                head_d  = '0;
              end
            end
            default: ;
          endcase
        end
      end

      S_DIV: begin
        rem_d  = div_ge ? KW'(div_sh - {1'b0, k_units}) : div_sh[KW-1:0];
        dvd_d  = dvd_q << 1;
        quo_d  = {quo_q[DW-2:0], div_ge};
        dcnt_d = dcnt_q - DCW'(1);
        if (dcnt_q == DCW'(1)) begin
          state_d = S_POST;
        end
      end

      S_POST: begin
        if (op_q == OP_ALLOC) begin
          // fresh page: one run from its first block, list was empty
          h_d     = IW'(IW'(pages_q) * BPP_U + IW'(1));
          link_d  = head_q;
          run_d   = RW'(quo_q);
          pages_d = pages_q + PW'(1);
          state_d = S_ALLOC;
        end else begin
          state_d = S_FIN;
          if (rem_q != '0) begin
            st_d = ST_MISALIGNED;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = IW'(IW'(q_slot) * BPP_U + IW'(q_off >> 4));
            ram_wdata = {head_q, RW'(1)};
            head_d    = ram_waddr;
            if (counted && cnt_q != '0) begin
              cnt_d = cnt_q - CNT_W'(1);
            end
          end
        end
      end

      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_WAIT;
      end

      S_WAIT: begin
        h_d     = head_q;
        link_d  = ram_rdata[IW+RW-1:RW];
        run_d   = ram_rdata[RW-1:0];
        state_d = S_ALLOC;
      end

      S_ALLOC: begin
        if (run_q > RW'(1)) begin
          ram_we    = 1'b1;
          ram_waddr = nxt_unit;
          ram_wdata = {link_q, RW'(run_q - RW'(1))};
          head_d    = nxt_unit;
        end else begin
          head_d = link_q;
        end
        if (counted && cnt_q != '1) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        urem_d  = h_q;
        slot_d  = '0;
        state_d = S_ADDR;
      end

      S_ADDR: begin
        // unit -> slot by repeated subtraction of the page unit count
        if (urem_q >= BPP_U) begin
          urem_d = urem_q - BPP_U;
          slot_d = slot_q + PW'(1);
        end else begin
          baddr_d = (ADDR_W'(slot_q) << PAGE_STRIDE_BITS) + (ADDR_W'(urem_q) << 4);
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        if (rsp_free) begin
          rsp_valid_d = 1'b1;
          rsp_st_d    = st_q;
          rsp_addr_d  = baddr_q;
          rsp_cnt_d   = cnt_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      pages_q     <= '0;
      cnt_q       <= '0;
      dcnt_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      pages_q     <= pages_d;
      cnt_q       <= cnt_d;
      dcnt_q      <= dcnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    addr_q     <= addr_d;
    dvd_q      <= dvd_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    h_q        <= h_d;
    link_q     <= link_d;
    run_q      <= run_d;
    urem_q     <= urem_d;
    slot_q     <= slot_d;
    st_q       <= st_d;
    baddr_q    <= baddr_d;
    rsp_st_q   <= rsp_st_d;
    rsp_addr_q <= rsp_addr_d;
    rsp_cnt_q  <= rsp_cnt_d;
  end

  // checks
  a_pages_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pages_q <= PW'(MAX_PAGES))
    else $error("open page count past MAX_PAGES");

  a_addr_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.status != ST_OK |-> rsp.block_address == '0)
    else $error("block address on a failed word");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while busy");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV && dcnt_q == DCW'(1) |=> state_q == S_POST)
    else $error("divider did not hand off");

endmodule
